@@ rtl/core/grnrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grnrc_pkg
// Shared types and constants of the grid neighbour reference counter.
// ----------------------------------------------------------------------------
package grnrc_pkg;

    localparam int MAX_CELLS  = 4096;
    localparam int CELL_W     = $clog2(MAX_CELLS);
    localparam int AREA_W     = CELL_W + 1;
    localparam int CNT_W      = 16;
    localparam int DIM_W      = 7;
    localparam int COORD_W    = 6;
    localparam int GRID_LIMIT = 64;
    localparam int NB_COUNT   = 9;
    localparam int NB_IDX_W   = $clog2(NB_COUNT);
    localparam int DIV_STEP_W = $clog2(CELL_W);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // neighbour visit order: N, NE, E, SE, S, SW, W, NW, center
    localparam logic signed [1:0] NB_DX [NB_COUNT] =
        '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0};
    localparam logic signed [1:0] NB_DY [NB_COUNT] =
        '{-2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd0};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_VISIT
    } state_t;

    // out-of-range dimension: 0 acts as 1, above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(GRID_LIMIT))
        begin
            r = DIM_W'(GRID_LIMIT);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/grnrc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grnrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module grnrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old value on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/grnrc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grnrc_div
// Restoring divider, one quotient bit per cycle: cell index -> row, column.
// ----------------------------------------------------------------------------
module grnrc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [grnrc_pkg::CELL_W-1:0] dividend,
    input  logic [grnrc_pkg::DIM_W-1:0]  divisor,
    output logic                         done,
    output logic [grnrc_pkg::CELL_W-1:0] quot,
    output logic [grnrc_pkg::DIM_W-1:0]  rem
);
    import grnrc_pkg::*;

    logic                  run_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [CELL_W-1:0]     quot_reg;
    logic [DIM_W-1:0]      rem_reg;
    logic [DIM_W-1:0]      dvs_reg;

    logic [DIM_W:0]        trial;
    logic                  fits;
    logic [DIM_W:0]        diff;

    always_comb
    begin
        trial = {rem_reg, quot_reg[CELL_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(CELL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[CELL_W-2:0], fits};
            rem_reg  <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ rtl/core/grid_neighbour_refcount_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_neighbour_refcount_unit
// Per-cell reference counts over a configurable grid, updated per move.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a move is accepted on a rising edge with start high and busy low.
//   It carries an optional old cell and an optional new cell (row-major).
//   Results: one per visited neighbour cell, each shown for exactly one cycle
//   with res_strobe high; the receiver cannot stall. Decrement-pass results
//   (raised = 0) come before increment-pass results (raised = 1); last marks
//   the final result of the move. A move with no visited cell gives nothing.
//   Flow: both cell indices are split into row/column by two serial
//   dividers running side by side. Then one neighbour is issued per cycle
//   through the single read port of the count memory, the write-back
//   following in the next cycle. A move with N visits (N <= 18) keeps busy
//   high through the divide and all N issues; the next move is taken only
//   once busy is low. Results of a move are back to back.
//   Reset: the count memory is swept to zero, one entry a cycle over all
//   4096 entries, with busy high. Config writes (cfg_we/cfg_index/cfg_data)
//   are taken at any time, including during that sweep; grid width and
//   height reset to 64.
// ----------------------------------------------------------------------------
module grid_neighbour_refcount_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            old_valid,
    input  logic [grnrc_pkg::CELL_W-1:0]    old_cell,
    input  logic                            new_valid,
    input  logic [grnrc_pkg::CELL_W-1:0]    new_cell,
    input  logic                            cfg_we,
    input  logic [grnrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grnrc_pkg::DIM_W-1:0]     cfg_data,
    output logic                            res_strobe,
    output logic [grnrc_pkg::CELL_W-1:0]    cell_res,
    output logic [grnrc_pkg::CNT_W-1:0]     count,
    output logic                            raised,
    output logic                            last
);
    import grnrc_pkg::*;

    // ---------------- configuration ----------------
    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [AREA_W-1:0] area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(GRID_LIMIT);
            grid_height_reg <= DIM_W'(GRID_LIMIT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign w_eff = clamp_dim(grid_width_reg);
    assign h_eff = clamp_dim(grid_height_reg);

    // cell count of the grid; at most 64 x 64, so never past MAX_CELLS
    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(w_eff * h_eff);
    end

    // ---------------- control ----------------
    state_t             state_reg, state_next;
    logic [CELL_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               accept;

    logic               old_valid_reg;
    logic [CELL_W-1:0]  old_cell_reg;
    logic               new_valid_reg;
    logic [CELL_W-1:0]  new_cell_reg;

    logic                pass_reg, pass_next;        // 0 old pass, 1 new pass
    logic [NB_COUNT-1:0] cur_mask_reg, cur_mask_next;
    logic [NB_COUNT-1:0] new_mask_reg, new_mask_next;

    // divider results
    logic               old_done, new_done, div_done;
    logic [CELL_W-1:0]  old_q, new_q;
    logic [DIM_W-1:0]   old_r, new_r;

    // neighbour masks once row and column are known
    logic [NB_COUNT-1:0] old_mask, new_mask;
    logic                old_present, new_present;

    // issue of one visit
    logic                issue;
    logic                issue_last;
    logic [NB_COUNT-1:0] pick_oh;
    logic [NB_COUNT-1:0] rest_mask;
    logic [NB_IDX_W-1:0] pick_idx;
    logic [CELL_W-1:0]   base_cell;
    logic [AREA_W-1:0]   row_off;
    logic [AREA_W-1:0]   col_off;
    logic [AREA_W-1:0]   nb_sum;
    logic [CELL_W-1:0]   issue_addr;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = state_reg != ST_IDLE;
    assign div_done = old_done && new_done;

    grnrc_div u_div_old (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (old_cell),
        .divisor  (w_eff),
        .done     (old_done),
        .quot     (old_q),
        .rem      (old_r)
    );

    grnrc_div u_div_new (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (new_cell),
        .divisor  (w_eff),
        .done     (new_done),
        .quot     (new_q),
        .rem      (new_r)
    );

    // in-grid neighbours of (x, y), in visit order
    function automatic logic [NB_COUNT-1:0] nb_mask(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [DIM_W-1:0]   w,
        input logic [DIM_W-1:0]   h
    );
        logic [NB_COUNT-1:0] m;
        logic x_lo, x_hi, y_lo, y_hi, ok_x, ok_y;
        x_lo = x != '0;
        x_hi = ({1'b0, x} + 1'b1) < w;
        y_lo = y != '0;
        y_hi = ({1'b0, y} + 1'b1) < h;
        for (int k = 0; k < NB_COUNT; k++)
        begin
            ok_x = (NB_DX[k] == -2'sd1) ? x_lo : ((NB_DX[k] == 2'sd1) ? x_hi : 1'b1);
            ok_y = (NB_DY[k] == -2'sd1) ? y_lo : ((NB_DY[k] == 2'sd1) ? y_hi : 1'b1);
            m[k] = ok_x && ok_y;
        end
        return m;
    endfunction

    always_comb
    begin
        old_present = old_valid_reg && ({1'b0, old_cell_reg} < area_reg);
        new_present = new_valid_reg && ({1'b0, new_cell_reg} < area_reg);
        old_mask = old_present ?
            nb_mask(old_r[COORD_W-1:0], old_q[COORD_W-1:0], w_eff, h_eff) : '0;
        new_mask = new_present ?
            nb_mask(new_r[COORD_W-1:0], new_q[COORD_W-1:0], w_eff, h_eff) : '0;
    end

    // next neighbour: lowest remaining bit of the current pass
    always_comb
    begin
        pick_oh   = cur_mask_reg & (~cur_mask_reg + 1'b1);
        rest_mask = cur_mask_reg & ~pick_oh;
        pick_idx  = '0;
        for (int k = 0; k < NB_COUNT; k++)
        begin
            if (pick_oh[k])
            begin
                pick_idx = NB_IDX_W'(k);
            end
        end
        base_cell = pass_reg ? new_cell_reg : old_cell_reg;
        case (NB_DY[pick_idx])
            -2'sd1:  row_off = -{{(AREA_W-DIM_W){1'b0}}, w_eff};
            2'sd1:   row_off = {{(AREA_W-DIM_W){1'b0}}, w_eff};
            default: row_off = '0;
        endcase
        col_off    = {{(AREA_W-2){NB_DX[pick_idx][1]}}, NB_DX[pick_idx]};
        nb_sum     = {1'b0, base_cell} + row_off + col_off;
        issue_addr = nb_sum[CELL_W-1:0];
        issue      = (state_reg == ST_VISIT) && (cur_mask_reg != '0);
        issue_last = (rest_mask == '0) && (pass_reg || (new_mask_reg == '0));
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pass_reg     <= 1'b0;
            cur_mask_reg <= '0;
            new_mask_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pass_reg     <= pass_next;
            cur_mask_reg <= cur_mask_next;
            new_mask_reg <= new_mask_next;
        end
    end

    // next state and sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pass_next     = pass_reg;
        cur_mask_next = cur_mask_reg;
        new_mask_next = new_mask_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    new_mask_next = new_mask;
                    if (old_mask != '0)
                    begin
                        pass_next     = 1'b0;
                        cur_mask_next = old_mask;
                        state_next    = ST_VISIT;
                    end
                    else if (new_mask != '0)
                    begin
                        pass_next     = 1'b1;
                        cur_mask_next = new_mask;
                        state_next    = ST_VISIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_VISIT:
            begin
                cur_mask_next = rest_mask;
                if (rest_mask == '0)
                begin
                    if (!pass_reg && (new_mask_reg != '0))
                    begin
                        pass_next     = 1'b1;
                        cur_mask_next = new_mask_reg;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // move payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_valid_reg <= old_valid;
            old_cell_reg  <= old_cell;
            new_valid_reg <= new_valid;
            new_cell_reg  <= new_cell;
        end
    end

    // ---------------- read-modify-write ----------------
    logic              b_valid_reg;
    logic [CELL_W-1:0] b_addr_reg;
    logic              b_raised_reg;
    logic              b_last_reg;
    logic              fwd_valid_reg;
    logic [CELL_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_data_reg;
    logic [CNT_W-1:0]  rd_data;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  upd_count;
    logic              clearing;
    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;

    logic              res_strobe_reg;
    logic [CELL_W-1:0] cell_res_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              raised_reg;
    logic              last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg    <= issue;
            fwd_valid_reg  <= b_valid_reg;
            res_strobe_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg   <= issue_addr;
        b_raised_reg <= pass_reg;
        b_last_reg   <= issue_last;
        fwd_addr_reg <= b_addr_reg;
        fwd_data_reg <= upd_count;
        cell_res_reg <= b_addr_reg;
        count_reg    <= upd_count;
        raised_reg   <= b_raised_reg;
        last_reg     <= b_last_reg;
    end

    // the write from the previous result is not in the read data yet: forward it
    always_comb
    begin
        cur_count = (fwd_valid_reg && (fwd_addr_reg == b_addr_reg)) ? fwd_data_reg : rd_data;
        if (b_raised_reg)
        begin
            upd_count = (cur_count == CNT_MAX) ? cur_count : cur_count + 1'b1;
        end
        else
        begin
            upd_count = (cur_count == '0) ? cur_count : cur_count - 1'b1;
        end
        clearing = state_reg == ST_CLEAR;
        wr_en    = clearing || b_valid_reg;
        wr_addr  = clearing ? clr_cnt_reg : b_addr_reg;
        wr_data  = clearing ? '0 : upd_count;
    end

    grnrc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CELLS)
    ) u_count_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (issue_addr),
        .rd_data (rd_data)
    );

    assign res_strobe = res_strobe_reg;
    assign cell_res   = cell_res_reg;
    assign count      = count_reg;
    assign raised     = raised_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

@@ rtl/core/grnrc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grnrc_checker
// Port-level checks of the refcount unit, bound to the top level.
// ----------------------------------------------------------------------------
module grnrc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            old_valid,
    input logic [grnrc_pkg::CELL_W-1:0]    old_cell,
    input logic                            new_valid,
    input logic [grnrc_pkg::CELL_W-1:0]    new_cell,
    input logic                            cfg_we,
    input logic [grnrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [grnrc_pkg::DIM_W-1:0]     cfg_data,
    input logic                            res_strobe,
    input logic [grnrc_pkg::CELL_W-1:0]    cell_res,
    input logic [grnrc_pkg::CNT_W-1:0]     count,
    input logic                            raised,
    input logic                            last
);

    // an accepted move keeps the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted transaction");

    // results of one move come back to back until last
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !last |=> res_strobe)
        else $error("gap inside a result burst");

    // the next move cannot produce a result right after last
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && last |=> !res_strobe)
        else $error("result directly after last");

    // decrement pass never follows the increment pass within a move
    a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && raised |=> !res_strobe || raised)
        else $error("decrement result after increment result");

endmodule

bind grid_neighbour_refcount_unit grnrc_checker u_grnrc_checker (.*);
`default_nettype wire

@@ tb/sv/grid_neighbour_refcount_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbour_refcount_unit_test
// Self-checking bench for the grid neighbour reference counter. Moves are
// sent through the start/busy handshake, a behavioral model of the count
// store predicts every neighbour update, and each strobed result is compared
// against the oldest prediction. Directed corner cases, grid shape changes,
// random entity walks and a count pile-up on a single cell are covered.
// ----------------------------------------------------------------------------
module grid_neighbour_refcount_unit_test;

    import grnrc_pkg::*;

    // worst-case move: set-up plus 18 visits and pipeline slack
    localparam int DRAIN_CYCLES  = 40;
    // bound on the wait for outstanding results before they count as missing
    localparam int SETTLE_LIMIT  = 2000;
    localparam int SHOWN_ERRORS  = 10;
    localparam int ENTITIES      = 6;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_MOVES   = 48;
    localparam int STACK_MOVES   = 20;

    // neighbour walk: N, NE, E, SE, S, SW, W, NW, then the cell itself
    localparam int STEP_DX [NB_COUNT] = '{0, 1, 1, 1, 0, -1, -1, -1, 0};
    localparam int STEP_DY [NB_COUNT] = '{-1, -1, 0, 1, 1, 1, 0, -1, 0};

    typedef struct packed {
        logic [CELL_W-1:0] addr;
        logic [CNT_W-1:0]  tally;
        logic              up;
        logic              fin;
    } cell_update_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 old_valid;
    logic [CELL_W-1:0]    old_cell;
    logic                 new_valid;
    logic [CELL_W-1:0]    new_cell;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 res_strobe;
    logic [CELL_W-1:0]    cell_res;
    logic [CNT_W-1:0]     count;
    logic                 raised;
    logic                 last;

    // model of the count store and the two dimension registers
    logic [CNT_W-1:0] cell_tally [MAX_CELLS];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    cell_update_t expected_updates [$];   // predicted, not yet seen
    cell_update_t move_batch [$];         // scratch for one move

    int mismatch_count;
    bit quiet;                            // no sender gaps while set

    grid_neighbour_refcount_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .old_valid  (old_valid),
        .old_cell   (old_cell),
        .new_valid  (new_valid),
        .new_cell   (new_cell),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_strobe (res_strobe),
        .cell_res   (cell_res),
        .count      (count),
        .raised     (raised),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // 0 behaves as 1, anything past 64 behaves as 64
    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > GRID_LIMIT)
        begin
            return GRID_LIMIT;
        end
        return int'(v);
    endfunction

    function automatic bit cell_present(input logic v, input logic [CELL_W-1:0] c);
        return v && (int'(c) < eff_dim(width_reg) * eff_dim(height_reg));
    endfunction

    // one pass over the 3x3 block around centre; up = increment pass
    task automatic tally_pass(input logic [CELL_W-1:0] centre, input logic up);
        int w;
        int h;
        int cx;
        int cy;
        int x;
        int y;
        int idx;
        logic [CNT_W-1:0] c;
        cell_update_t upd;
        w  = eff_dim(width_reg);
        h  = eff_dim(height_reg);
        cx = int'(centre) % w;
        cy = int'(centre) / w;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            x = cx + STEP_DX[i];
            y = cy + STEP_DY[i];
            if (x >= 0 && y >= 0 && x < w && y < h)
            begin
                idx = y * w + x;
                c   = cell_tally[idx];
                if (up)
                begin
                    if (c != CNT_MAX)
                    begin
                        c = c + 1'b1;
                    end
                end
                else if (c != '0)
                begin
                    c = c - 1'b1;
                end
                cell_tally[idx] = c;
                upd = '{addr: CELL_W'(idx), tally: c, up: up, fin: 1'b0};
                move_batch = {move_batch, upd};
            end
        end
    endtask

    // decrement pass for the old cell, then increment pass for the new one
    task automatic predict_move(input logic ov, input logic [CELL_W-1:0] oc,
                                input logic nv, input logic [CELL_W-1:0] nc);
        move_batch.delete();
        if (cell_present(ov, oc))
        begin
            tally_pass(oc, 1'b0);
        end
        if (cell_present(nv, nc))
        begin
            tally_pass(nc, 1'b1);
        end
        if (move_batch.size() > 0)
        begin
            move_batch[move_batch.size() - 1].fin = 1'b1;
        end
        expected_updates = {expected_updates, move_batch};
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobed result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_update_t want;
        if (rst_n && res_strobe)
        begin
            if (expected_updates.size() == 0)
            begin
                if (mismatch_count < SHOWN_ERRORS)
                begin
                    $display("unexpected result: cell %0d count %0d raised %0b last %0b",
                             cell_res, count, raised, last);
                end
                mismatch_count++;
            end
            else
            begin
                want = expected_updates.pop_front();
                if (cell_res !== want.addr || count !== want.tally ||
                    raised !== want.up || last !== want.fin)
                begin
                    if (mismatch_count < SHOWN_ERRORS)
                    begin
                        $display("mismatch: expected cell %0d count %0d raised %0b last %0b,",
                                 want.addr, want.tally, want.up, want.fin);
                        $display("          got      cell %0d count %0d raised %0b last %0b",
                                 cell_res, count, raised, last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver helpers
    // ------------------------------------------------------------------------

    // mostly back to back or short, now and then a long pause
    function automatic int pick_gap();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    // One transaction. start stays high after acceptance so a following
    // move with no gap goes out without a low cycle in between.
    task automatic send_move(input logic ov, input logic [CELL_W-1:0] oc,
                             input logic nv, input logic [CELL_W-1:0] nc);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        old_valid <= ov;
        old_cell  <= oc;
        new_valid <= nv;
        new_cell  <= nc;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_move(ov, oc, nv, nc);
    endtask

    // Wait for the block to go quiet. A move with no result may still be in
    // flight when the queue empties, hence the extra cycles. Results that
    // never show up within the bound count as errors.
    task automatic settle();
        int waited;
        start  <= 1'b0;
        waited = 0;
        while (expected_updates.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_updates.size() != 0)
        begin
            $display("missing %0d results", expected_updates.size());
            mismatch_count += expected_updates.size();
            expected_updates.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // write both dimension registers, one per cycle, block idle
    task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        width_reg = w;
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        height_reg = h;
        cfg_we <= 1'b0;
    endtask

    function automatic int clamp_coord(input int v, input int lim);
        if (v < 0)
        begin
            return 0;
        end
        if (v >= lim)
        begin
            return lim - 1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // default 64x64 grid: corners, edges, interior, same cell, zero counts
    task automatic test_corner_moves();
        send_move(1'b0, 12'd4095, 1'b1, 12'd0);       // NW corner
        send_move(1'b0, 12'd0,    1'b1, 12'd63);      // NE corner
        send_move(1'b0, 12'd0,    1'b1, 12'd4032);    // SW corner
        send_move(1'b0, 12'd0,    1'b1, 12'd4095);    // SE corner, all ones
        send_move(1'b0, 12'd0,    1'b1, 12'd2080);    // interior, nine visits
        send_move(1'b1, 12'd2080, 1'b1, 12'd2080);    // same cell, both passes
        send_move(1'b1, 12'd0,    1'b0, 12'd4095);    // leave only
        send_move(1'b1, 12'd1000, 1'b0, 12'd0);       // counts already at zero
        send_move(1'b0, 12'd4095, 1'b0, 12'd4095);    // nothing given: no result
        send_move(1'b1, 12'd64,   1'b1, 12'd127);     // west edge to east edge
        settle();
    endtask

    // register extremes and grids that make cells absent
    task automatic test_grid_shapes();
        set_grid(7'd0, 7'd0);                         // acts as 1x1
        send_move(1'b0, 12'd0, 1'b1, 12'd0);
        send_move(1'b1, 12'd0, 1'b1, 12'd1);          // new cell off the grid
        settle();
        set_grid(7'd5, 7'd3);
        send_move(1'b0, 12'd0,  1'b1, 12'd14);        // last cell of the grid
        send_move(1'b1, 12'd15, 1'b1, 12'd7);         // old cell off the grid
        send_move(1'b1, 12'd7,  1'b1, 12'd4095);
        settle();
        set_grid(7'd64, 7'd1);                        // single row
        send_move(1'b0, 12'd0, 1'b1, 12'd63);
        send_move(1'b0, 12'd0, 1'b1, 12'd64);         // just past the end
        settle();
        set_grid(7'd1, 7'd64);                        // single column
        send_move(1'b1, 12'd2, 1'b1, 12'd63);
        settle();
        set_grid(7'd127, 7'd65);                      // both clamp to 64
        send_move(1'b1, 12'd4095, 1'b1, 12'd4095);
        settle();
    endtask

    // Entities walk the grid: short hops between neighbouring cells and jumps,
    // about half each, spawns and removals, plus raw noise on all fields.
    task automatic test_random_moves();
        int ent_pos [ENTITIES];
        bit ent_live [ENTITIES];
        int w;
        int h;
        int k;
        int r;
        int dest;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: set_grid(7'd64, 7'd64);
                1: set_grid(7'd1, 7'd0);
                2: set_grid(7'd127, 7'd3);
                default: set_grid(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)));
            endcase
            w     = eff_dim(width_reg);
            h     = eff_dim(height_reg);
            quiet = ($urandom_range(0, 3) == 0);
            foreach (ent_live[i])
            begin
                ent_live[i] = 1'b0;
                ent_pos[i]  = 0;
            end
            for (int n = 0; n < PHASE_MOVES; n++)
            begin
                k = $urandom_range(0, ENTITIES - 1);
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 0)
                begin
                    dest = clamp_coord(ent_pos[k] / w + $urandom_range(0, 2) - 1, h) * w +
                           clamp_coord(ent_pos[k] % w + $urandom_range(0, 2) - 1, w);
                end
                else
                begin
                    dest = $urandom_range(0, w * h - 1);
                end
                if (r < 75 && !ent_live[k])
                begin
                    send_move(1'b0, CELL_W'($urandom), 1'b1, CELL_W'(dest));
                    ent_live[k] = 1'b1;
                    ent_pos[k]  = dest;
                end
                else if (r < 65)
                begin
                    send_move(1'b1, CELL_W'(ent_pos[k]), 1'b1, CELL_W'(dest));
                    ent_pos[k] = dest;
                end
                else if (r < 75)
                begin
                    send_move(1'b1, CELL_W'(ent_pos[k]), 1'b0, CELL_W'($urandom));
                    ent_live[k] = 1'b0;
                end
                else
                begin
                    send_move(1'($urandom), CELL_W'($urandom), 1'($urandom), CELL_W'($urandom));
                end
            end
            settle();
        end
        quiet = 1'b0;
    endtask

    // 1x1 grid: the single count piles up, then drains and holds at zero
    task automatic test_count_stack();
        set_grid(7'd1, 7'd1);
        repeat (STACK_MOVES)
        begin
            send_move(1'b0, CELL_W'($urandom), 1'b1, 12'd0);
        end
        send_move(1'b1, 12'd0, 1'b1, 12'd0);
        repeat (STACK_MOVES + 2)
        begin
            send_move(1'b1, 12'd0, 1'b0, CELL_W'($urandom));
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        old_valid <= 1'b0;
        old_cell  <= '0;
        new_valid <= 1'b0;
        new_cell  <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= '0;
        width_reg  = DIM_W'(GRID_LIMIT);
        height_reg = DIM_W'(GRID_LIMIT);
        mismatch_count = 0;
        quiet = 1'b0;
        foreach (cell_tally[i])
        begin
            cell_tally[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // first move waits out the clearing sweep through busy
        test_corner_moves();
        test_grid_shapes();
        test_random_moves();
        test_count_stack();

        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog. It allows about five times the slowest legal run (clearing
    // sweep plus every move under the longest gaps).
    initial
    begin
        #(2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
